// ----- design/per_class_box_suppression_macros.svh -----
// Assertion macros shared by the per-class box suppression RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef PER_CLASS_BOX_SUPPRESSION_MACROS_SVH
`define PER_CLASS_BOX_SUPPRESSION_MACROS_SVH

// Plain property check.
`define PCBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next cycle.
`define PCBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/pcbs_pkg.sv -----
// ----------------------------------------------------------------------------
// pcbs_pkg
// Types, constants and the ranking function of the per-class box suppression.
// ----------------------------------------------------------------------------
package pcbs_pkg;

  localparam int unsigned MaxBoxes = 64;

  localparam logic [15:0] ScoreThrReset   = 16'd32768;
  localparam logic [15:0] OverlapThrReset = 16'd29491;

  // Configuration register indexes.
  localparam logic [7:0] CfgScoreThr   = 8'd0;
  localparam logic [7:0] CfgOverlapThr = 8'd1;

  typedef struct packed {
    logic [15:0] cx;
    logic [15:0] cy;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] score;
    logic [7:0]  cls;
  } box_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic valid;
    logic take;
    box_t box;
  } link_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP
  } cell_op_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_POP,
    ST_CHECK,
    ST_RD,
    ST_MUL,
    ST_UNI,
    ST_PROD,
    ST_CMP,
    ST_KEEP,
    ST_FLUSH
  } state_e;

  // True when box a sorts strictly ahead of box b: lower class first, then
  // higher score. Equal keys keep arrival order.
  function automatic logic rank_before(box_t a, box_t b);
    logic r;
    if (a.cls != b.cls) begin
      r = (a.cls < b.cls);
    end else begin
      r = (a.score > b.score);
    end
    return r;
  endfunction

endpackage

// ----- design/pcbs_if.sv -----
// ----------------------------------------------------------------------------
// pcbs interfaces
// Valid/ready channels for candidate boxes, results and register writes.
// ----------------------------------------------------------------------------
interface pcbs_box_if;
  logic        valid;
  logic        ready;
  logic [15:0] center_x;
  logic [15:0] center_y;
  logic [15:0] box_width;
  logic [15:0] box_height;
  logic [15:0] score;
  logic [7:0]  class_index;
  logic        last_box;

  modport source (output valid, center_x, center_y, box_width, box_height, score,
                  class_index, last_box, input ready);
  modport sink (input valid, center_x, center_y, box_width, box_height, score,
                class_index, last_box, output ready);
endinterface

interface pcbs_res_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_center_x;
  logic [15:0] out_center_y;
  logic [15:0] out_width;
  logic [15:0] out_height;
  logic [15:0] out_score;
  logic [7:0]  out_class;
  logic        none_kept;
  logic        last_result;

  modport source (output valid, out_center_x, out_center_y, out_width, out_height,
                  out_score, out_class, none_kept, last_result, input ready);
  modport sink (input valid, out_center_x, out_center_y, out_width, out_height,
                out_score, out_class, none_kept, last_result, output ready);
endinterface

interface pcbs_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- design/pcbs_ram.sv -----
// ----------------------------------------------------------------------------
// pcbs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pcbs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- design/pcbs_cell.sv -----
// ----------------------------------------------------------------------------
// pcbs_cell
// One slot of the sorting chain: holds a box, takes its left neighbor's box
// or the new box on insertion, and its right neighbor's box on a pop.
// ----------------------------------------------------------------------------
module pcbs_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pcbs_pkg::cell_op_e op_i,
  input  pcbs_pkg::box_t    new_box_i,
  input  pcbs_pkg::link_t   left_i,
  input  pcbs_pkg::link_t   right_i,
  output pcbs_pkg::link_t   link_o
);

  logic           valid_q, valid_d;
  pcbs_pkg::box_t box_q, box_d;
  logic           take;

  // The new box belongs here or further left.
  assign take = !valid_q || pcbs_pkg::rank_before(new_box_i, box_q);

  always_comb begin
    valid_d = valid_q;
    box_d   = box_q;
    unique case (op_i)
      pcbs_pkg::OP_INSERT: begin
        if (take) begin
          if (left_i.take) begin
            valid_d = left_i.valid;
            box_d   = left_i.box;
          end else begin
            valid_d = 1'b1;
            box_d   = new_box_i;
          end
        end
      end
      pcbs_pkg::OP_POP: begin
        valid_d = right_i.valid;
        box_d   = right_i.box;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    box_q <= box_d;
  end

  assign link_o = '{valid: valid_q, take: take, box: box_q};

endmodule

// ----- design/per_class_box_suppression.sv -----
// ----------------------------------------------------------------------------
// per_class_box_suppression
// Per-class non-maximum suppression over a frame of candidate boxes.
// ----------------------------------------------------------------------------
// Candidate boxes are taken one per cycle while the block loads. A box whose
// score is above the score threshold is inserted, in the same cycle, into a
// chain of MAX_BOXES cells that keeps the boxes sorted by ascending class and
// descending score, ties in arrival order; once every cell holds a box,
// further boxes are dropped. After the request that carries last_box, no new
// request is taken until the frame's results have been worked out. The chain
// then shifts its boxes out from the head one per pop. Each popped box is
// checked against the boxes already kept in its class, which sit in a small
// RAM; one shared overlap unit does each check in steps (RAM read, edge and
// area stage, intersection multiply, union, threshold multiply, compare) and
// the check stops at the first overlap that suppresses. A frame needs the
// most pairwise checks when all its boxes share one class and none is
// suppressed. Results go out through an output register, and the newest
// survivor waits in a pending register, so the block goes on working while
// a result waits, until the next survivor or the final result has to move
// on; the final result carries last_result, and a frame with no survivor
// gives one result with none_kept set and all other fields zero. Register
// writes are taken at any time and meant to be made while the block is idle.
// ----------------------------------------------------------------------------
`include "per_class_box_suppression_macros.svh"

module per_class_box_suppression #(
  parameter int unsigned MAX_BOXES = pcbs_pkg::MaxBoxes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcbs_box_if.sink   boxes_i,
  pcbs_res_if.source results_o,
  pcbs_cfg_if.sink   cfg_i
);

  localparam int unsigned CntW = $clog2(MAX_BOXES + 1);
  localparam int unsigned IdxW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

  // Configuration registers.
  logic [15:0] score_thr_q, overlap_thr_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_thr_q   <= pcbs_pkg::ScoreThrReset;
      overlap_thr_q <= pcbs_pkg::OverlapThrReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        pcbs_pkg::CfgScoreThr:   score_thr_q   <= cfg_i.data;
        pcbs_pkg::CfgOverlapThr: overlap_thr_q <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // The incoming request as a box.
  pcbs_pkg::box_t in_box;
  assign in_box = '{cx: boxes_i.center_x, cy: boxes_i.center_y,
                    w: boxes_i.box_width, h: boxes_i.box_height,
                    score: boxes_i.score, cls: boxes_i.class_index};

  // Sorting chain.
  pcbs_pkg::cell_op_e chain_op;
  pcbs_pkg::link_t    link [MAX_BOXES];
  pcbs_pkg::link_t    head;
  logic               chain_full;

  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    pcbs_pkg::link_t left, right;
    if (i == 0) begin : g_first
      assign left = '{valid: 1'b0, take: 1'b0, box: in_box};
    end else begin : g_mid_l
      assign left = link[i-1];
    end
    if (i == MAX_BOXES - 1) begin : g_last
      assign right = '{valid: 1'b0, take: 1'b0, box: in_box};
    end else begin : g_mid_r
      assign right = link[i+1];
    end
    pcbs_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .op_i      (chain_op),
      .new_box_i (in_box),
      .left_i    (left),
      .right_i   (right),
      .link_o    (link[i])
    );
  end

  assign head       = link[0];
  assign chain_full = link[MAX_BOXES-1].valid;

  // Control and datapath registers.
  pcbs_pkg::state_e state_q, state_d;
  pcbs_pkg::box_t   cand_q, cand_d;
  pcbs_pkg::box_t   pend_q, pend_d;
  logic             pend_valid_q, pend_valid_d;
  logic [CntW-1:0]  kept_cnt_q, kept_cnt_d;
  logic [7:0]       kept_cls_q, kept_cls_d;
  logic [CntW-1:0]  idx_q, idx_d;

  logic [16:0] iw_q, ih_q;
  logic [31:0] area_a_q, area_b_q;
  logic [33:0] inter_q;
  logic [32:0] area_sum_q;
  logic [34:0] union_q;
  logic [50:0] prod_q;

  // Output register.
  pcbs_pkg::box_t res_box_q, res_box_d;
  logic           res_valid_q, res_none_q, res_none_d, res_last_q, res_last_d;
  logic           out_load, out_free;

  // Kept-box RAM.
  logic           ram_we;
  pcbs_pkg::box_t ram_rdata;

  pcbs_ram #(
    .Width ($bits(pcbs_pkg::box_t)),
    .Depth (MAX_BOXES)
  ) u_kept_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (kept_cnt_q[IdxW-1:0]),
    .wdata_i (cand_q),
    .raddr_i (idx_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Edge stage: edges in doubled units, intersection sides, clipped at zero.
  logic signed [18:0] l1, r1, l2, r2, t1, b1, t2, b2, il, ir, it, ib, dw, dh;
  logic               overlap;

  always_comb begin
    l1 = $signed({2'b0, cand_q.cx, 1'b0}) - $signed({3'b0, cand_q.w});
    r1 = $signed({2'b0, cand_q.cx, 1'b0}) + $signed({3'b0, cand_q.w});
    t1 = $signed({2'b0, cand_q.cy, 1'b0}) - $signed({3'b0, cand_q.h});
    b1 = $signed({2'b0, cand_q.cy, 1'b0}) + $signed({3'b0, cand_q.h});
    l2 = $signed({2'b0, ram_rdata.cx, 1'b0}) - $signed({3'b0, ram_rdata.w});
    r2 = $signed({2'b0, ram_rdata.cx, 1'b0}) + $signed({3'b0, ram_rdata.w});
    t2 = $signed({2'b0, ram_rdata.cy, 1'b0}) - $signed({3'b0, ram_rdata.h});
    b2 = $signed({2'b0, ram_rdata.cy, 1'b0}) + $signed({3'b0, ram_rdata.h});
    il = (l1 > l2) ? l1 : l2;
    ir = (r1 < r2) ? r1 : r2;
    it = (t1 > t2) ? t1 : t2;
    ib = (b1 < b2) ? b1 : b2;
    dw = ir - il;
    dh = ib - it;
    overlap = !((it > ib) || (il > ir));
  end

  assign out_free = !res_valid_q || results_o.ready;

  assign boxes_i.ready = (state_q == pcbs_pkg::ST_LOAD);

  always_comb begin
    state_d      = state_q;
    cand_d       = cand_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    kept_cnt_d   = kept_cnt_q;
    kept_cls_d   = kept_cls_q;
    idx_d        = idx_q;
    chain_op     = pcbs_pkg::OP_HOLD;
    ram_we       = 1'b0;
    out_load     = 1'b0;
    res_box_d    = res_box_q;
    res_none_d   = res_none_q;
    res_last_d   = res_last_q;

    unique case (state_q)
      pcbs_pkg::ST_LOAD: begin
        if (boxes_i.valid) begin
          if ((boxes_i.score > score_thr_q) && !chain_full) begin
            chain_op = pcbs_pkg::OP_INSERT;
          end
          if (boxes_i.last_box) begin
            state_d = pcbs_pkg::ST_POP;
          end
        end
      end
      pcbs_pkg::ST_POP: begin
        if (head.valid) begin
          chain_op = pcbs_pkg::OP_POP;
          cand_d   = head.box;
          idx_d    = '0;
          if (head.box.cls != kept_cls_q) begin
            kept_cnt_d = '0;
            kept_cls_d = head.box.cls;
          end
          state_d = pcbs_pkg::ST_CHECK;
        end else begin
          state_d = pcbs_pkg::ST_FLUSH;
        end
      end
      pcbs_pkg::ST_CHECK: begin
        if (idx_q == kept_cnt_q) begin
          // No kept box of this class overlaps too much: keep it.
          ram_we     = 1'b1;
          kept_cnt_d = kept_cnt_q + 1'b1;
          state_d    = pcbs_pkg::ST_KEEP;
        end else begin
          state_d = pcbs_pkg::ST_RD;
        end
      end
      pcbs_pkg::ST_RD:   state_d = pcbs_pkg::ST_MUL;
      pcbs_pkg::ST_MUL:  state_d = pcbs_pkg::ST_UNI;
      pcbs_pkg::ST_UNI:  state_d = pcbs_pkg::ST_PROD;
      pcbs_pkg::ST_PROD: state_d = pcbs_pkg::ST_CMP;
      pcbs_pkg::ST_CMP: begin
        if ({1'b0, inter_q, 16'b0} > prod_q) begin
          state_d = pcbs_pkg::ST_POP;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = pcbs_pkg::ST_CHECK;
        end
      end
      pcbs_pkg::ST_KEEP: begin
        // The previous survivor is known not to be the last one now.
        if (!pend_valid_q) begin
          pend_d       = cand_q;
          pend_valid_d = 1'b1;
          state_d      = pcbs_pkg::ST_POP;
        end else if (out_free) begin
          out_load   = 1'b1;
          res_box_d  = pend_q;
          res_none_d = 1'b0;
          res_last_d = 1'b0;
          pend_d     = cand_q;
          state_d    = pcbs_pkg::ST_POP;
        end
      end
      pcbs_pkg::ST_FLUSH: begin
        if (out_free) begin
          out_load     = 1'b1;
          res_box_d    = pend_valid_q ? pend_q : '0;
          res_none_d   = !pend_valid_q;
          res_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          kept_cnt_d   = '0;
          state_d      = pcbs_pkg::ST_LOAD;
        end
      end
      default: state_d = pcbs_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pcbs_pkg::ST_LOAD;
      pend_valid_q <= 1'b0;
      kept_cnt_q   <= '0;
      kept_cls_q   <= '0;
      idx_q        <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      kept_cnt_q   <= kept_cnt_d;
      kept_cls_q   <= kept_cls_d;
      idx_q        <= idx_d;
      if (out_load) begin
        res_valid_q <= 1'b1;
      end else if (results_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Payload and overlap pipeline registers.
  always_ff @(posedge clk_i) begin
    cand_q     <= cand_d;
    pend_q     <= pend_d;
    res_box_q  <= res_box_d;
    res_none_q <= res_none_d;
    res_last_q <= res_last_d;
    iw_q       <= overlap ? dw[16:0] : '0;
    ih_q       <= overlap ? dh[16:0] : '0;
    area_a_q   <= cand_q.w * cand_q.h;
    area_b_q   <= ram_rdata.w * ram_rdata.h;
    inter_q    <= iw_q * ih_q;
    area_sum_q <= {1'b0, area_a_q} + {1'b0, area_b_q};
    union_q    <= {area_sum_q, 2'b0} - {1'b0, inter_q};
    prod_q     <= overlap_thr_q * union_q;
  end

  assign results_o.valid        = res_valid_q;
  assign results_o.out_center_x = res_box_q.cx;
  assign results_o.out_center_y = res_box_q.cy;
  assign results_o.out_width    = res_box_q.w;
  assign results_o.out_height   = res_box_q.h;
  assign results_o.out_score    = res_box_q.score;
  assign results_o.out_class    = res_box_q.cls;
  assign results_o.none_kept    = res_none_q;
  assign results_o.last_result  = res_last_q;

  // The final request of a frame is taken in this cycle.
  logic last_taken;
  assign last_taken = boxes_i.valid && boxes_i.ready && boxes_i.last_box;

  // The kept list never outgrows the store.
  `PCBS_ASSERT(a_kept_bound, kept_cnt_q <= CntW'(MAX_BOXES), "kept count beyond store")
  // A check never reads past the kept boxes of the class.
  `PCBS_ASSERT(a_idx_bound, (state_q != pcbs_pkg::ST_CHECK) || (idx_q <= kept_cnt_q), "idx")
  // A result is loaded only when the output register is free.
  `PCBS_ASSERT(a_out_free, !out_load || !res_valid_q || results_o.ready, "result overwritten")
  // The final request of a frame starts the result pass.
  `PCBS_ASSERT_NEXT(a_last_pop, last_taken, state_q == pcbs_pkg::ST_POP, "no result pass")

endmodule

// ----- test/tb_per_class_box_suppression.sv -----
// ----------------------------------------------------------------------------
// tb_per_class_box_suppression
// Self-checking bench for the per-class box suppression block.
// ----------------------------------------------------------------------------
// Frames of candidate boxes are driven with random gaps and the results are
// taken with random stalls. A scoreboard keeps its own copy of the frame
// store and the thresholds, works out the surviving boxes of every frame in
// class and score order, and compares each result with the oldest one due.
// ----------------------------------------------------------------------------
module tb_per_class_box_suppression;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned SettleCycles = 40;

  // One result as the block presents it.
  typedef struct packed {
    pcbs_pkg::box_t box;
    logic none;
    logic last;
  } kept_t;

  // Holds the frame store, predicts the survivors and checks the results.
  class nms_scoreboard;
    logic [15:0]    score_thr;
    logic [15:0]    overlap_thr;
    pcbs_pkg::box_t frame_boxes[pcbs_pkg::MaxBoxes];
    int unsigned    box_count;
    kept_t          kept_q[$];
    int unsigned    errors;

    function new();
      score_thr   = pcbs_pkg::ScoreThrReset;
      overlap_thr = pcbs_pkg::OverlapThrReset;
      box_count   = 0;
      errors      = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    function void set_reg(logic [7:0] idx, logic [15:0] data);
      if (idx == pcbs_pkg::CfgScoreThr) begin
        score_thr = data;
      end else if (idx == pcbs_pkg::CfgOverlapThr) begin
        overlap_thr = data;
      end
    endfunction

    // Appends one expected result at the tail.
    function void add_expected(kept_t k);
      kept_q = {kept_q, k};
    endfunction

    // Lower class first, then higher score; equal keys keep arrival order.
    function bit sorts_ahead(pcbs_pkg::box_t a, pcbs_pkg::box_t b);
      if (a.cls != b.cls) return a.cls < b.cls;
      return a.score > b.score;
    endfunction

    // IoU above the threshold, tested as 65536*inter > thr*union on edges
    // that are kept in doubled units so that the half sizes stay exact.
    function bit overlaps_too_much(pcbs_pkg::box_t a, pcbs_pkg::box_t b);
      longint la, ra, ta, ba, lb, rb, tb, bb, il, ir, it, ib;
      longint inter4, union4;
      la = 2 * longint'(a.cx) - longint'(a.w);
      ra = 2 * longint'(a.cx) + longint'(a.w);
      ta = 2 * longint'(a.cy) - longint'(a.h);
      ba = 2 * longint'(a.cy) + longint'(a.h);
      lb = 2 * longint'(b.cx) - longint'(b.w);
      rb = 2 * longint'(b.cx) + longint'(b.w);
      tb = 2 * longint'(b.cy) - longint'(b.h);
      bb = 2 * longint'(b.cy) + longint'(b.h);
      il = (la > lb) ? la : lb;
      ir = (ra < rb) ? ra : rb;
      it = (ta > tb) ? ta : tb;
      ib = (ba < bb) ? ba : bb;
      if (it > ib || il > ir) return 1'b0;
      inter4 = (ir - il) * (ib - it);
      union4 = 4 * longint'(a.w) * longint'(a.h) + 4 * longint'(b.w) * longint'(b.h)
               - inter4;
      return (inter4 * 65536) > (longint'(overlap_thr) * union4);
    endfunction

    // Works out the survivors of the stored frame and clears the store.
    function void run_suppression();
      int unsigned ord[pcbs_pkg::MaxBoxes];
      bit [pcbs_pkg::MaxBoxes-1:0] gone;
      int unsigned i, j, v, n_kept;
      kept_t k;
      for (i = 0; i < box_count; i++) begin
        v = i;
        j = i;
        while (j > 0 && sorts_ahead(frame_boxes[v], frame_boxes[ord[j-1]])) begin
          ord[j] = ord[j-1];
          j--;
        end
        ord[j] = v;
      end
      gone = '0;
      n_kept = 0;
      for (i = 0; i < box_count; i++) begin
        if (!gone[i]) begin
          k.box  = frame_boxes[ord[i]];
          k.none = 1'b0;
          k.last = 1'b0;
          add_expected(k);
          n_kept++;
          for (j = i + 1; j < box_count; j++) begin
            if (frame_boxes[ord[j]].cls == k.box.cls && !gone[j] &&
                overlaps_too_much(k.box, frame_boxes[ord[j]])) begin
              gone[j] = 1'b1;
            end
          end
        end
      end
      if (n_kept == 0) begin
        k = '0;
        k.none = 1'b1;
        k.last = 1'b1;
        add_expected(k);
      end else begin
        kept_q[kept_q.size() - 1].last = 1'b1;
      end
      box_count = 0;
    endfunction

    function void note_box(pcbs_pkg::box_t b, logic last);
      if (b.score > score_thr && box_count < pcbs_pkg::MaxBoxes) begin
        frame_boxes[box_count] = b;
        box_count++;
      end
      if (last) run_suppression();
    endfunction

    task cmp(string field, int got, int want);
      if (got != want) report($sformatf("%s got %0d expected %0d", field, got, want));
    endtask

    task check_result(kept_t got);
      kept_t want;
      if (kept_q.size() == 0) begin
        report("result arrived with none expected");
      end else begin
        want = kept_q.pop_front();
        cmp("center_x", got.box.cx, want.box.cx);
        cmp("center_y", got.box.cy, want.box.cy);
        cmp("width", got.box.w, want.box.w);
        cmp("height", got.box.h, want.box.h);
        cmp("score", got.box.score, want.box.score);
        cmp("class", got.box.cls, want.box.cls);
        cmp("none_kept", got.none, want.none);
        cmp("last_result", got.last, want.last);
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  pcbs_box_if box_if ();
  pcbs_res_if res_if ();
  pcbs_cfg_if cfg_if ();

  per_class_box_suppression u_top (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .boxes_i  (box_if),
    .results_o(res_if),
    .cfg_i    (cfg_if)
  );

  nms_scoreboard sb = new();

  // Idling switches; cleared to get stretches at full rate.
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;
  int unsigned boxes_sent = 0;
  // Long receiver hold-off, counted down by the receiver itself.
  int unsigned recv_hold = 0;
  int unsigned recv_wait = 0;
  int unsigned cycles = 0;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: ready changes on the falling edge. A long hold takes priority,
  // then the per-result wait drawn when the previous result was taken.
  always @(negedge clk) begin
    if (recv_hold > 0) begin
      res_if.ready = 1'b0;
      recv_hold--;
    end else if (recv_wait > 0) begin
      res_if.ready = 1'b0;
      recv_wait--;
    end else begin
      res_if.ready = 1'b1;
    end
  end

  // Every accepted result is checked at the rising edge that takes it.
  always @(posedge clk) begin
    kept_t got;
    if (rst_n && res_if.valid && res_if.ready) begin
      got.box.cx    = res_if.out_center_x;
      got.box.cy    = res_if.out_center_y;
      got.box.w     = res_if.out_width;
      got.box.h     = res_if.out_height;
      got.box.score = res_if.out_score;
      got.box.cls   = res_if.out_class;
      got.none      = res_if.none_kept;
      got.last      = res_if.last_result;
      sb.check_result(got);
      recv_wait = recv_gaps ? $urandom_range(0, 7) : 0;
    end
  end

  // Offers one candidate box and returns on the falling edge after it was
  // taken. Valid stays high when the next request follows without a gap.
  task send_box(pcbs_pkg::box_t b, logic last);
    int unsigned gap;
    gap = send_gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      box_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    box_if.valid       = 1'b1;
    box_if.center_x    = b.cx;
    box_if.center_y    = b.cy;
    box_if.box_width   = b.w;
    box_if.box_height  = b.h;
    box_if.score       = b.score;
    box_if.class_index = b.cls;
    box_if.last_box    = last;
    @(posedge clk);
    while (!box_if.ready) @(posedge clk);
    sb.note_box(b, last);
    boxes_sent++;
    @(negedge clk);
  endtask

  task write_reg(logic [7:0] idx, logic [15:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Waits until every predicted result has come, then lets the block settle.
  task drain();
    box_if.valid = 1'b0;
    while (sb.kept_q.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task set_thresholds(logic [15:0] score_thr, logic [15:0] overlap_thr);
    drain();
    write_reg(pcbs_pkg::CfgScoreThr, score_thr);
    write_reg(pcbs_pkg::CfgOverlapThr, overlap_thr);
  endtask

  function automatic pcbs_pkg::box_t mk_box(int cx, int cy, int w, int h, int s, int c);
    pcbs_pkg::box_t b;
    b.cx = 16'(cx);
    b.cy = 16'(cy);
    b.w = 16'(w);
    b.h = 16'(h);
    b.score = 16'(s);
    b.cls = 8'(c);
    return b;
  endfunction

  // A frame of clustered boxes in a few neighboring classes, so that boxes
  // of one class overlap often; now and then a box with every field random.
  task send_frame(int unsigned n);
    pcbs_pkg::box_t b;
    int unsigned base_x, base_y, base_c, k;
    base_x = $urandom_range(0, 65535);
    base_y = $urandom_range(0, 65535);
    base_c = $urandom_range(0, 255);
    send_gaps = ($urandom_range(0, 3) != 0);
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        b.cx    = 16'($urandom);
        b.cy    = 16'($urandom);
        b.w     = 16'($urandom);
        b.h     = 16'($urandom);
        b.score = 16'($urandom);
        b.cls   = 8'($urandom);
      end else begin
        b.cx    = 16'(base_x + $urandom_range(0, 40));
        b.cy    = 16'(base_y + $urandom_range(0, 40));
        b.w     = 16'($urandom_range(0, 200));
        b.h     = 16'($urandom_range(0, 200));
        b.score = 16'($urandom_range(0, 65535));
        b.cls   = 8'(base_c + $urandom_range(0, 2));
      end
      send_box(b, k == n - 1);
    end
  endtask

  initial begin
    logic [15:0] cfg_score[6];
    logic [15:0] cfg_overlap[6];
    int unsigned phase, budget;

    rst_n = 1'b0;
    box_if.valid = 1'b0;
    box_if.center_x = '0;
    box_if.center_y = '0;
    box_if.box_width = '0;
    box_if.box_height = '0;
    box_if.score = '0;
    box_if.class_index = '0;
    box_if.last_box = 1'b0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    cfg_score   = '{16'd0, 16'd65535, 16'd1000, 16'd32768, 16'd0, 16'd20000};
    cfg_overlap = '{16'd0, 16'd65535, 16'd65535, 16'd0, 16'd0, 16'd29491};
    cfg_score[4]   = 16'($urandom_range(0, 40000));
    cfg_overlap[4] = 16'($urandom_range(0, 65535));

    set_thresholds(pcbs_pkg::ScoreThrReset, pcbs_pkg::OverlapThrReset);

    // Directed frame. Two zero-area boxes never suppress each other, an
    // identical box of equal score loses to the one that came first, a box
    // that only touches survives, boxes at the far corners use full-range
    // fields, a score equal to the threshold is dropped and one just above
    // it is stored but suppressed by a stronger overlapping box of its class.
    send_box(mk_box(0, 0, 0, 0, 32769, 0), 1'b0);
    send_box(mk_box(0, 0, 0, 0, 40000, 0), 1'b0);
    send_box(mk_box(100, 100, 20, 20, 50000, 3), 1'b0);
    send_box(mk_box(100, 100, 20, 20, 50000, 3), 1'b0);
    send_box(mk_box(120, 100, 20, 20, 60000, 3), 1'b0);
    send_box(mk_box(65535, 65535, 65535, 65535, 65535, 255), 1'b0);
    send_box(mk_box(0, 65535, 65535, 0, 65534, 255), 1'b0);
    send_box(mk_box(1000, 1000, 100, 100, 32768, 1), 1'b0);
    send_box(mk_box(1000, 1000, 100, 100, 32769, 1), 1'b0);
    send_box(mk_box(1005, 1000, 100, 100, 40000, 1), 1'b0);
    send_box(mk_box(65535, 0, 65535, 65535, 0, 128), 1'b1);
    // Empty frame: the only box is below the threshold.
    send_box(mk_box(500, 500, 10, 10, 100, 7), 1'b1);
    // Two frames in a row with no gaps on the input side.
    send_gaps = 1'b0;
    send_box(mk_box(200, 200, 50, 50, 65535, 9), 1'b0);
    send_box(mk_box(210, 205, 50, 50, 65000, 9), 1'b1);
    send_box(mk_box(300, 300, 40, 40, 50000, 2), 1'b1);
    send_gaps = 1'b1;

    for (phase = 0; phase < 6; phase++) begin
      set_thresholds(cfg_score[phase], cfg_overlap[phase]);
      recv_gaps = (phase != 4);
      budget = boxes_sent + 72;
      if (phase == 0) begin
        // Store full: everything above a zero threshold is kept, so the
        // boxes past the capacity are the ones dropped.
        send_frame(pcbs_pkg::MaxBoxes + 6);
      end
      if (phase == 3) begin
        // The receiver holds off while frames keep coming, so the block
        // fills its output side and stops taking boxes.
        recv_hold = 400;
        send_frame(20);
        send_frame(8);
        send_frame(5);
      end
      while (boxes_sent < budget) begin
        send_frame(($urandom_range(0, 4) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 8));
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/pcbs_pkg.sv
design/pcbs_if.sv
design/pcbs_ram.sv
design/pcbs_cell.sv
design/per_class_box_suppression.sv
test/tb_per_class_box_suppression.sv
